>>> src/glyph_alpha_blit_with_underline_assert.svh
// Assertion macros for the glyph alpha blit block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef GLYPH_ALPHA_BLIT_WITH_UNDERLINE_ASSERT_SVH
`define GLYPH_ALPHA_BLIT_WITH_UNDERLINE_ASSERT_SVH

// same-cycle implication
`define GAB_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gab: implication failed");

// next-cycle implication
`define GAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gab: next-cycle check failed");

`endif

>>> src/gab_pkg.sv
// Shared types and constants for the glyph alpha blit block.
// No dependencies.
`default_nettype none

package gab_pkg;

	localparam int LANES      = 8;
	localparam int LANE_IDX_W = 3;
	localparam int PROD_W     = 14;
	localparam int BASE_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_BYTE   = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	localparam logic [1:0] FMT_MONO = 2'd0;
	localparam logic [1:0] FMT_GRAY = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_W   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_H   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UL_OFS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UL_ROWS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UL_ON    = 3'd5;

	localparam logic [7:0] ALPHA_FULL = 8'hFF;
	localparam logic [7:0] ALPHA_NONE = 8'h00;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         glyph_width;
		logic [7:0]         glyph_rows;
		logic signed [15:0] bearing_x;
		logic signed [15:0] bearing_y;
		logic [1:0]         pixel_format;
		logic [7:0]         src_row;
		logic [7:0]         src_col;
		logic [7:0]         src_byte;
		logic [5:0]         read_x;
		logic [5:0]         read_y;
	} item_t;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} lane_t;

endpackage

`default_nettype wire

>>> src/gab_if.sv
// Handshake interfaces: glyph item, result and register write channels.
// Depends on gab_pkg.
`default_nettype none

interface glyph_in_if import gab_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         glyph_width;
	logic [7:0]         glyph_rows;
	logic signed [15:0] bearing_x;
	logic signed [15:0] bearing_y;
	logic [1:0]         pixel_format;
	logic [7:0]         src_row;
	logic [7:0]         src_col;
	logic [7:0]         src_byte;
	logic [5:0]         read_x;
	logic [5:0]         read_y;

	modport source(output valid, mode, glyph_width, glyph_rows, bearing_x, bearing_y,
		pixel_format, src_row, src_col, src_byte, read_x, read_y, input ready);
	modport sink(input valid, mode, glyph_width, glyph_rows, bearing_x, bearing_y,
		pixel_format, src_row, src_col, src_byte, read_x, read_y, output ready);
endinterface

interface glyph_out_if import gab_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] alpha;
	logic       is_read_reply;

	modport source(output valid, alpha, is_read_reply, input ready);
	modport sink(input valid, alpha, is_read_reply, output ready);
endinterface

interface glyph_cfg_if import gab_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/gab_lane.sv
// One pixel lane: source-width and cell clipping for a single pixel of a beat.
// Depends on gab_pkg.
`default_nettype none

module gab_lane import gab_pkg::*; (
	input  logic        fmt_ok,
	input  logic        mono,
	input  logic        row_ok,
	input  logic [10:0] sx,
	input  logic [7:0]  lat_width,
	input  logic [8:0]  px,
	input  logic [6:0]  eff_w,
	input  logic        sbit,
	input  logic [7:0]  sbyte,
	output lane_t       lane
);

	logic [11:0] col;

	always_comb begin
		col       = {1'b0, sx} + {3'b000, px};
		lane.en   = fmt_ok && row_ok && (sx < {3'b000, lat_width}) && (col < {5'b0, eff_w});
		lane.data = mono ? (sbit ? ALPHA_FULL : ALPHA_NONE) : sbyte;
	end

endmodule

`default_nettype wire

>>> src/gab_bank.sv
// One bank of the cell store: one write and one registered read per cycle.
// No package dependencies.
`default_nettype none

module gab_bank #(
	parameter int DEPTH = 512,
	parameter int IDX_W = 9
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [7:0]       rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

>>> src/gab_merge.sv
// Routes the eight lanes, or the clearing or underline sweep, onto the eight store banks.
// Depends on gab_pkg.
`default_nettype none

module gab_merge import gab_pkg::*; #(
	parameter int IDX_W  = 9,
	parameter int SPAN_W = 13
) (
	input  logic [BASE_W-1:0] base,
	input  lane_t             lanes [LANES],
	input  logic              go,
	input  logic              sweep_on,
	input  logic [IDX_W-1:0]  sweep_idx,
	input  logic [SPAN_W-1:0] sweep_lo,
	input  logic [SPAN_W-1:0] sweep_hi,
	input  logic              sweep_fill,
	output logic              wr_en   [LANES],
	output logic [IDX_W-1:0]  wr_idx  [LANES],
	output logic [7:0]        wr_data [LANES]
);

	for (genvar j = 0; j < LANES; j++) begin : g_bank
		logic [LANE_IDX_W-1:0] off;
		logic [BASE_W:0]       addr;
		logic [31:0]           saddr;

		always_comb begin
			off   = LANE_IDX_W'(j) - base[LANE_IDX_W-1:0];
			addr  = {1'b0, base} + {{(BASE_W+1-LANE_IDX_W){1'b0}}, off};
			saddr = {sweep_idx, LANE_IDX_W'(j)};
			if (sweep_on) begin
				wr_en[j]   = (saddr >= 32'(sweep_lo)) && (saddr < 32'(sweep_hi));
				wr_idx[j]  = sweep_idx;
				wr_data[j] = sweep_fill ? ALPHA_FULL : ALPHA_NONE;
			end else begin
				wr_en[j]   = go && lanes[off].en;
				wr_idx[j]  = IDX_W'(addr >> LANE_IDX_W);
				wr_data[j] = lanes[off].data;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/glyph_alpha_blit_with_underline.sv
// Glyph alpha blit with underline: top level.
// Usage:
//  item   : one beat per command (start, source byte, finish, read); one result beat each.
//  result : alpha and is_read_reply; alpha is the pixel on a read, zero otherwise.
//  cfg    : register writes (index, data), always ready; write only while idle.
// Source-byte and read beats stream at one per cycle while result.ready is high
// and no sweep runs; each beat passes the input register, the address/bank stage
// and the output register. A mono byte writes up to eight pixels in the same
// cycle through eight lanes onto an eight-bank store interleaved on address bits [2:0].
// A start beat clears the store, all ceil(MAX_CELL_W*MAX_CELL_H/8) rows (512 at 64x64),
// one row of all banks a cycle. A finish beat with underline on fills the clipped
// rows. item.ready stays low during either sweep.
// After reset the same clearing sweep runs before the first item is taken; cfg
// writes are accepted throughout.
// When the receiver stalls, the output register holds its beat and the two stages
// behind it still fill, then item.ready drops.
`default_nettype none
`include "glyph_alpha_blit_with_underline_assert.svh"

module glyph_alpha_blit_with_underline import gab_pkg::*; #(
	parameter int MAX_CELL_W = 64,
	parameter int MAX_CELL_H = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	glyph_in_if.sink     item,
	glyph_out_if.source  result,
	glyph_cfg_if.sink    cfg
);

	localparam int CELLS  = MAX_CELL_W * MAX_CELL_H;
	localparam int DEPTH  = (CELLS + LANES - 1) / LANES;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int SPAN_W = $clog2(CELLS + 1);

	// registers
	logic [6:0]        cell_w_q, cell_h_q, ul_rows_q;
	logic signed [7:0] baseline_q, ul_ofs_q;
	logic              ul_on_q;

	// glyph state
	logic [8:0]        place_x_q;
	logic signed [9:0] place_y_q;
	logic [7:0]        lat_width_q;
	logic [1:0]        lat_fmt_q;

	// control
	logic busy_q;
	logic sweep_q, sweep_fill_q;
	logic [IDX_W-1:0]  sweep_k_q, sweep_end_q;
	logic [SPAN_W-1:0] sweep_lo_q, sweep_hi_q;

	// pipeline
	logic              v_s1, v_s2, v_s3;
	item_t             it_s1;
	logic [1:0]        mode_s2;
	lane_t             lanes_s2 [LANES];
	logic [PROD_W-1:0] prod_s2, hi_s2;
	logic [11:0]       colbase_s2;
	logic              ulgo_s2, rdok_s2;
	logic              rd_s3, rdok_s3;
	logic [LANE_IDX_W-1:0] bsel_s3;

	logic en1, en2, en3, accept;
	logic [6:0] eff_w, eff_h;

	assign eff_w = (32'(cell_w_q) > MAX_CELL_W) ? 7'(MAX_CELL_W) : cell_w_q;
	assign eff_h = (32'(cell_h_q) > MAX_CELL_H) ? 7'(MAX_CELL_H) : cell_h_q;

	assign en3    = !v_s3 || result.ready;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign accept = item.valid && item.ready;

	assign item.ready = en1 && !busy_q;
	assign cfg.ready  = 1'b1;

	item_t it_in;
	always_comb begin
		it_in.mode         = item.mode;
		it_in.glyph_width  = item.glyph_width;
		it_in.glyph_rows   = item.glyph_rows;
		it_in.bearing_x    = item.bearing_x;
		it_in.bearing_y    = item.bearing_y;
		it_in.pixel_format = item.pixel_format;
		it_in.src_row      = item.src_row;
		it_in.src_col      = item.src_col;
		it_in.src_byte     = item.src_byte;
		it_in.read_x       = item.read_x;
		it_in.read_y       = item.read_y;
	end

	// ---------------- stage 1: decode, placement, clipping, products
	logic [8:0]         ox;
	logic signed [16:0] by_adj;
	logic signed [10:0] tb;
	logic signed [11:0] oy;
	logic signed [9:0]  oy_sat;
	logic signed [10:0] row;
	logic               row_ok, mono, gray, byte_mode, rdok;
	logic signed [8:0]  ul_start;
	logic signed [9:0]  ul_end;
	logic [6:0]         r0, r1, mul_a;
	logic [11:0]        colbase;
	logic [PROD_W-1:0]  prod, prod_hi;
	lane_t              lanes_s1 [LANES];

	always_comb begin
		ox = it_s1.bearing_x[15] ? 9'd0 : it_s1.bearing_x[14:6];
		if (it_s1.glyph_width >= {1'b0, cell_w_q}) begin
			ox = 9'd0;
		end
		by_adj = {it_s1.bearing_y[15], it_s1.bearing_y}
			+ (it_s1.bearing_y[15] ? 17'sd63 : 17'sd0);
		tb = by_adj[16:6];
		oy = 12'(baseline_q) - 12'(tb);
		if ((it_s1.glyph_rows >= {1'b0, cell_h_q}) && (oy > 12'sd0)) begin
			oy = 12'sd0;
		end
		if (oy < -12'sd512) begin
			oy_sat = -10'sd512;
		end else if (oy > 12'sd511) begin
			oy_sat = 10'sd511;
		end else begin
			oy_sat = oy[9:0];
		end

		mono      = (lat_fmt_q == FMT_MONO);
		gray      = (lat_fmt_q == FMT_GRAY);
		byte_mode = (it_s1.mode == MODE_BYTE);
		row       = $signed({3'b000, it_s1.src_row}) + 11'(place_y_q);
		row_ok    = !row[10] && (row < $signed({4'b0000, eff_h}));
		rdok      = ({1'b0, it_s1.read_x} < eff_w) && ({1'b0, it_s1.read_y} < eff_h);

		ul_start = 9'(baseline_q) + 9'(ul_ofs_q);
		ul_end   = 10'(ul_start) + $signed({3'b000, ul_rows_q});
		if (ul_start < 9'sd0) begin
			r0 = 7'd0;
		end else if (ul_start > $signed({2'b00, eff_h})) begin
			r0 = eff_h;
		end else begin
			r0 = ul_start[6:0];
		end
		if (ul_end < 10'sd0) begin
			r1 = 7'd0;
		end else if (ul_end > $signed({3'b000, eff_h})) begin
			r1 = eff_h;
		end else begin
			r1 = ul_end[6:0];
		end

		case (it_s1.mode)
			MODE_READ: begin
				mul_a   = {1'b0, it_s1.read_y};
				colbase = {6'd0, it_s1.read_x};
			end
			MODE_BYTE: begin
				mul_a   = row[6:0];
				colbase = (mono ? {1'b0, it_s1.src_col, 3'b000} : {4'd0, it_s1.src_col})
					+ {3'b000, place_x_q};
			end
			default: begin
				mul_a   = r0;
				colbase = 12'd0;
			end
		endcase
		prod    = mul_a * eff_w;
		prod_hi = r1 * eff_w;
	end

	for (genvar b = 0; b < LANES; b++) begin : g_lane
		logic [10:0] sx;
		logic        fmt_ok;
		assign sx = mono ? ({it_s1.src_col, 3'b000} + 11'(b)) : {3'b000, it_s1.src_col};
		assign fmt_ok = byte_mode && (mono || (gray && (b == 0)));

		gab_lane u_lane (
			.fmt_ok    (fmt_ok),
			.mono      (mono),
			.row_ok    (row_ok),
			.sx        (sx),
			.lat_width (lat_width_q),
			.px        (place_x_q),
			.eff_w     (eff_w),
			.sbit      (it_s1.src_byte[LANES-1-b]),
			.sbyte     (it_s1.src_byte),
			.lane      (lanes_s1[b])
		);
	end

	// ---------------- stage 2: address, bank routing
	logic [BASE_W-1:0] base;
	logic              wr_en   [LANES];
	logic [IDX_W-1:0]  wr_idx  [LANES];
	logic [7:0]        wr_data [LANES];
	logic              rd_en;
	logic [7:0]        rd_data [LANES];

	assign base  = BASE_W'(prod_s2) + BASE_W'(colbase_s2);
	assign rd_en = v_s2 && en3 && (mode_s2 == MODE_READ) && rdok_s2;

	gab_merge #(.IDX_W(IDX_W), .SPAN_W(SPAN_W)) u_merge (
		.base       (base),
		.lanes      (lanes_s2),
		.go         (v_s2 && en3 && (mode_s2 == MODE_BYTE)),
		.sweep_on   (sweep_q),
		.sweep_idx  (sweep_k_q),
		.sweep_lo   (sweep_lo_q),
		.sweep_hi   (sweep_hi_q),
		.sweep_fill (sweep_fill_q),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data)
	);

	for (genvar j = 0; j < LANES; j++) begin : g_store
		gab_bank #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_bank (
			.clk     (clk),
			.wr_en   (wr_en[j]),
			.wr_idx  (wr_idx[j]),
			.wr_data (wr_data[j]),
			.rd_en   (rd_en),
			.rd_idx  (IDX_W'(base >> LANE_IDX_W)),
			.rd_data (rd_data[j])
		);
	end

	// ---------------- stage 3: output register
	assign result.valid         = v_s3;
	assign result.is_read_reply = rd_s3;
	assign result.alpha         = (rd_s3 && rdok_s3) ? rd_data[bsel_s3] : ALPHA_NONE;

	// ---------------- clocked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w_q   <= 7'd16;
			cell_h_q   <= 7'd16;
			baseline_q <= 8'sd12;
			ul_ofs_q   <= 8'sd0;
			ul_rows_q  <= 7'd1;
			ul_on_q    <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CELL_W:   cell_w_q   <= cfg.data[6:0];
				REG_CELL_H:   cell_h_q   <= cfg.data[6:0];
				REG_BASELINE: baseline_q <= cfg.data;
				REG_UL_OFS:   ul_ofs_q   <= cfg.data;
				REG_UL_ROWS:  ul_rows_q  <= cfg.data[6:0];
				REG_UL_ON:    ul_on_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_x_q   <= 9'd0;
			place_y_q   <= 10'sd0;
			lat_width_q <= 8'd0;
			lat_fmt_q   <= FMT_MONO;
		end else if (v_s1 && en2 && (it_s1.mode == MODE_START)) begin
			place_x_q   <= ox;
			place_y_q   <= oy_sat;
			lat_width_q <= it_s1.glyph_width;
			lat_fmt_q   <= it_s1.pixel_format;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			it_s1 <= it_in;
		end
		if (en2) begin
			mode_s2    <= it_s1.mode;
			lanes_s2   <= lanes_s1;
			prod_s2    <= prod;
			hi_s2      <= prod_hi;
			colbase_s2 <= colbase;
			ulgo_s2    <= ul_on_q && (r1 > r0);
			rdok_s2    <= rdok;
		end
		if (en3) begin
			rd_s3   <= (mode_s2 == MODE_READ);
			rdok_s3 <= rdok_s2;
			bsel_s3 <= base[LANE_IDX_W-1:0];
		end
	end

	// clearing and underline sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b1;
			sweep_q      <= 1'b1;
			sweep_fill_q <= 1'b0;
			sweep_k_q    <= '0;
			sweep_end_q  <= IDX_W'(DEPTH - 1);
			sweep_lo_q   <= '0;
			sweep_hi_q   <= SPAN_W'(CELLS);
		end else if (sweep_q) begin
			if (sweep_k_q == sweep_end_q) begin
				sweep_q <= 1'b0;
				busy_q  <= 1'b0;
			end else begin
				sweep_k_q <= sweep_k_q + 1'b1;
			end
		end else if (accept && ((item.mode == MODE_START) || (item.mode == MODE_FINISH))) begin
			busy_q <= 1'b1;
		end else if (v_s2 && en3 && (mode_s2 == MODE_START)) begin
			sweep_q      <= 1'b1;
			sweep_fill_q <= 1'b0;
			sweep_k_q    <= '0;
			sweep_end_q  <= IDX_W'(DEPTH - 1);
			sweep_lo_q   <= '0;
			sweep_hi_q   <= SPAN_W'(CELLS);
		end else if (v_s2 && en3 && (mode_s2 == MODE_FINISH)) begin
			if (ulgo_s2) begin
				sweep_q      <= 1'b1;
				sweep_fill_q <= 1'b1;
				sweep_k_q    <= IDX_W'(prod_s2 >> LANE_IDX_W);
				sweep_end_q  <= IDX_W'((hi_s2 - 1'b1) >> LANE_IDX_W);
				sweep_lo_q   <= SPAN_W'(prod_s2);
				sweep_hi_q   <= SPAN_W'(hi_s2);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// ---------------- checks
	`GAB_ASSERT_IMPLY(a_no_accept_in_sweep, sweep_q, !item.ready)
	`GAB_ASSERT_IMPLY(a_sweep_alone, sweep_q, !v_s2 && !v_s1)
	`GAB_ASSERT_IMPLY(a_alpha_zero_else, result.valid && !result.is_read_reply, result.alpha == ALPHA_NONE)
	`GAB_ASSERT_NEXT(a_sweep_ends, sweep_q && (sweep_k_q == sweep_end_q), !sweep_q && !busy_q)

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the glyph alpha blit with underline: drives glyph commands and
// register writes, predicts every result beat from its own copy of the cell and compares.
// Depends on gab_pkg, the gab_if interfaces and the glyph_alpha_blit_with_underline top.

module tb;
	import gab_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [7:0] alpha;
		logic       is_read_reply;
	} pixel_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	glyph_in_if  glyph_in();
	glyph_out_if glyph_out();
	glyph_cfg_if reg_wr();

	glyph_alpha_blit_with_underline i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (glyph_in),
		.result(glyph_out),
		.cfg   (reg_wr)
	);

	always #1 clk = ~clk;

	// shadow of the block's state and registers
	logic [7:0]        cell_shadow [0:4095];
	int                place_x, place_y;
	logic [7:0]        lat_width;
	logic [1:0]        lat_format;
	logic [6:0]        cfg_cw = 7'd16;
	logic [6:0]        cfg_ch = 7'd16;
	logic signed [7:0] cfg_base = 8'sd12;
	logic signed [7:0] cfg_ofs = 8'sd0;
	logic [6:0]        cfg_rows = 7'd1;
	logic              cfg_on = 1'b0;

	item_t        glyph_cmds[$];
	pixel_reply_t replies_due[$];
	item_t        on_wire;

	bit in_fire, out_fire;
	bit burst;
	int send_gap, recv_stall, stall_cycles;
	int phase_cmds, n_items, n_starts, n_reads, n_lit, n_settings, fail_count;

	function automatic int eff_width();
		return cfg_cw > 64 ? 64 : int'(cfg_cw);
	endfunction

	function automatic int eff_height();
		return cfg_ch > 64 ? 64 : int'(cfg_ch);
	endfunction

	function automatic void put_px(int col, int row, logic [7:0] v);
		int w, h;
		w = eff_width();
		h = eff_height();
		if (col >= 0 && row >= 0 && col < w && row < h)
			cell_shadow[row * w + col] = v;
	endfunction

	task automatic apply_glyph_cmd(input item_t c, output pixel_reply_t r);
		int ox, oy, bx, by, base, row, col, srow, b, i, x, w, h;
		w = eff_width();
		h = eff_height();
		base = cfg_base;
		r = '0;
		case (c.mode)
			MODE_START: begin
				bx = $signed(c.bearing_x);
				by = $signed(c.bearing_y);
				ox = bx / 64;
				oy = base - by / 64;
				foreach (cell_shadow[k])
					cell_shadow[k] = '0;
				lat_width = c.glyph_width;
				lat_format = c.pixel_format;
				if (ox < 0)
					ox = 0;
				if (c.glyph_width >= cfg_cw && ox > 0)
					ox = 0;
				if (c.glyph_rows >= cfg_ch && oy > 0)
					oy = 0;
				if (oy < -512)
					oy = -512;
				if (oy > 511)
					oy = 511;
				place_x = ox;
				place_y = oy;
			end
			MODE_BYTE: begin
				srow = c.src_row;
				row = srow + place_y;
				if (lat_format == FMT_MONO) begin
					for (b = 0; b < 8; b++) begin
						col = int'(c.src_col) * 8 + b;
						if (col < int'(lat_width))
							put_px(col + place_x, row,
								c.src_byte[7 - b] ? ALPHA_FULL : ALPHA_NONE);
					end
				end else if (lat_format == FMT_GRAY) begin
					if (c.src_col < lat_width)
						put_px(int'(c.src_col) + place_x, row, c.src_byte);
				end
			end
			MODE_FINISH: begin
				if (cfg_on) begin
					for (i = 0; i < int'(cfg_rows); i++)
						for (x = 0; x < w; x++)
							put_px(x, base + int'(cfg_ofs) + i, ALPHA_FULL);
				end
			end
			default: begin
				r.is_read_reply = 1'b1;
				if (int'(c.read_x) < w && int'(c.read_y) < h)
					r.alpha = cell_shadow[int'(c.read_y) * w + int'(c.read_x)];
			end
		endcase
	endtask

	// item driver
	always @(negedge clk) begin : drive_glyph
		item_t c;
		if (!arst_n) begin
			glyph_in.valid <= 1'b0;
		end else if (!glyph_in.valid || in_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				glyph_in.valid <= 1'b0;
			end else if (glyph_cmds.size() > 0) begin
				c = glyph_cmds.pop_front();
				on_wire = c;
				glyph_in.valid        <= 1'b1;
				glyph_in.mode         <= c.mode;
				glyph_in.glyph_width  <= c.glyph_width;
				glyph_in.glyph_rows   <= c.glyph_rows;
				glyph_in.bearing_x    <= c.bearing_x;
				glyph_in.bearing_y    <= c.bearing_y;
				glyph_in.pixel_format <= c.pixel_format;
				glyph_in.src_row      <= c.src_row;
				glyph_in.src_col      <= c.src_col;
				glyph_in.src_byte     <= c.src_byte;
				glyph_in.read_x       <= c.read_x;
				glyph_in.read_y       <= c.read_y;
				send_gap = burst ? 0 : $urandom_range(0, 10);
			end else begin
				glyph_in.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			glyph_out.ready <= 1'b0;
		end else begin
			if (out_fire)
				recv_stall = burst ? 0 : $urandom_range(0, 10);
			if (recv_stall > 0) begin
				recv_stall--;
				glyph_out.ready <= 1'b0;
			end else begin
				glyph_out.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted items, check result beats
	always @(posedge clk) begin : observe
		pixel_reply_t want;
		in_fire = arst_n && glyph_in.valid && glyph_in.ready;
		out_fire = arst_n && glyph_out.valid && glyph_out.ready;
		if (in_fire) begin
			n_items++;
			if (on_wire.mode == MODE_START)
				n_starts++;
			apply_glyph_cmd(on_wire, want);
			replies_due.push_back(want);
		end
		if (out_fire) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result beat: alpha %0d is_read_reply %0d",
					glyph_out.alpha, glyph_out.is_read_reply);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (glyph_out.alpha !== want.alpha) begin
					$error("alpha: expected %0d, got %0d", want.alpha, glyph_out.alpha);
					fail_count++;
				end
				if (glyph_out.is_read_reply !== want.is_read_reply) begin
					$error("is_read_reply: expected %0d, got %0d",
						want.is_read_reply, glyph_out.is_read_reply);
					fail_count++;
				end
				if (want.is_read_reply) begin
					n_reads++;
					if (want.alpha != 0)
						n_lit++;
				end
			end
		end
		if (!arst_n || in_fire || out_fire || (reg_wr.valid && reg_wr.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("** glyph_alpha_blit_with_underline: FAILED **");
		$finish;
	end

	function automatic item_t noise_cmd();
		logic [95:0] r;
		item_t c;
		r = {$urandom, $urandom, $urandom};
		c = r[$bits(item_t)-1:0];
		return c;
	endfunction

	function automatic item_t cmd_of(logic [1:0] mode);
		item_t c;
		c = noise_cmd();
		c.mode = mode;
		return c;
	endfunction

	function automatic item_t cmd_start(int gw, int gr, int bx, int by, logic [1:0] fmt);
		item_t c;
		c = cmd_of(MODE_START);
		c.glyph_width = 8'(gw);
		c.glyph_rows = 8'(gr);
		c.bearing_x = 16'(bx);
		c.bearing_y = 16'(by);
		c.pixel_format = fmt;
		return c;
	endfunction

	function automatic item_t cmd_byte(int row, int col, int val);
		item_t c;
		c = cmd_of(MODE_BYTE);
		c.src_row = 8'(row);
		c.src_col = 8'(col);
		c.src_byte = 8'(val);
		return c;
	endfunction

	function automatic item_t cmd_read(int x, int y);
		item_t c;
		c = cmd_of(MODE_READ);
		c.read_x = 6'(x);
		c.read_y = 6'(y);
		return c;
	endfunction

	function automatic void push_cmd(item_t c);
		glyph_cmds.push_back(c);
		phase_cmds++;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		reg_wr.valid <= 1'b1;
		reg_wr.index <= idx;
		reg_wr.data <= val;
		do
			@(posedge clk);
		while (!reg_wr.ready);
		case (idx)
			REG_CELL_W:   cfg_cw = val[6:0];
			REG_CELL_H:   cfg_ch = val[6:0];
			REG_BASELINE: cfg_base = val;
			REG_UL_OFS:   cfg_ofs = val;
			REG_UL_ROWS:  cfg_rows = val[6:0];
			REG_UL_ON:    cfg_on = val[0];
			default: ;
		endcase
		@(negedge clk);
		reg_wr.valid <= 1'b0;
	endtask

	// top bits of the narrower registers carry noise, they must be dropped
	task automatic set_regs(int cw, int ch, int base, int ofs, int rows, int on);
		write_reg(REG_UL_ON, {7'($urandom), 1'(on)});
		write_reg(REG_CELL_W, {1'($urandom), 7'(cw)});
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
		write_reg(REG_CELL_H, {1'($urandom), 7'(ch)});
		write_reg(REG_BASELINE, 8'(base));
		write_reg(REG_UL_OFS, 8'(ofs));
		write_reg(REG_UL_ROWS, {1'($urandom), 7'(rows)});
		n_settings++;
	endtask

	// hold off until every beat is back and no sweep is running
	task automatic drain();
		do
			@(posedge clk);
		while (glyph_cmds.size() != 0 || glyph_in.valid || !glyph_in.ready
			|| replies_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_glyph();
		item_t c;
		int w, h, rmax_x, rmax_y, base, gw, gr, t, bx, by, n, k;
		logic [1:0] fmt;
		w = eff_width();
		h = eff_height();
		rmax_x = w > 63 ? 63 : w;
		rmax_y = h > 63 ? 63 : h;
		base = cfg_base;
		gw = $urandom_range(1, w + 4);
		gr = $urandom_range(1, h + 4);
		bx = $urandom_range(0, w) * 64 + $urandom_range(0, 63);
		if ($urandom_range(0, 5) == 0)
			bx = -$urandom_range(0, 300);
		t = $urandom_range(0, h + 2);
		t = t - 2;
		by = (base - t) * 64 + $urandom_range(0, 126) - 63;
		k = $urandom_range(0, 19);
		fmt = k < 9 ? FMT_MONO : k < 17 ? FMT_GRAY : 2'($urandom_range(2, 3));
		if ($urandom_range(0, 9) == 0)
			c = cmd_of(MODE_START);
		else
			c = cmd_start(gw, gr, bx, by, fmt);
		push_cmd(c);
		gw = c.glyph_width;
		gr = c.glyph_rows;
		fmt = c.pixel_format;
		n = $urandom_range(4, 24);
		repeat (n) begin
			k = $urandom_range(0, 99);
			if (k < 65)
				push_cmd(cmd_byte($urandom_range(0, gr),
					$urandom_range(0, fmt == FMT_MONO ? (gw + 7) / 8 : gw), $urandom));
			else if (k < 90)
				push_cmd(cmd_read($urandom_range(0, rmax_x), $urandom_range(0, rmax_y)));
			else if (k < 95)
				push_cmd(cmd_of(MODE_FINISH));
			else
				push_cmd(noise_cmd());
		end
		if ($urandom_range(0, 1))
			push_cmd(cmd_of(MODE_FINISH));
		repeat (4)
			push_cmd(cmd_read($urandom_range(0, rmax_x), $urandom_range(0, rmax_y)));
	endtask

	task automatic run_phase(int cw, int ch, int base, int ofs, int rows, int on,
		bit no_idle, int budget);
		drain();
		set_regs(cw, ch, base, ofs, rows, on);
		burst = no_idle;
		phase_cmds = 0;
		while (phase_cmds < budget)
			queue_glyph();
	endtask

	initial begin : stimulus
		int p;
		foreach (cell_shadow[k])
			cell_shadow[k] = '0;
		place_x = 0;
		place_y = 0;
		lat_width = '0;
		lat_format = '0;
		glyph_in.valid = 1'b0;
		{glyph_in.mode, glyph_in.glyph_width, glyph_in.glyph_rows, glyph_in.bearing_x,
			glyph_in.bearing_y, glyph_in.pixel_format, glyph_in.src_row, glyph_in.src_col,
			glyph_in.src_byte, glyph_in.read_x, glyph_in.read_y} = '0;
		glyph_out.ready = 1'b0;
		reg_wr.valid = 1'b0;
		reg_wr.index = '0;
		reg_wr.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: placement, clipping, truncation, formats, underline
		set_regs(16, 16, 12, 0, 2, 1);
		burst = 1'b0;
		push_cmd(cmd_read(0, 0));
		push_cmd(cmd_start(12, 10, 191, 640, FMT_MONO));
		push_cmd(cmd_byte(0, 0, 8'hFF));
		push_cmd(cmd_byte(1, 1, 8'hA5));
		push_cmd(cmd_byte(255, 255, 8'h81));
		push_cmd(cmd_read(2, 2));
		push_cmd(cmd_read(12, 3));
		push_cmd(cmd_read(63, 63));
		push_cmd(cmd_of(MODE_FINISH));
		push_cmd(cmd_read(5, 13));
		push_cmd(cmd_start(255, 255, -32768, 32767, FMT_GRAY));
		push_cmd(cmd_byte(255, 0, 8'h7E));
		push_cmd(cmd_read(0, 0));
		push_cmd(cmd_start(4, 3, 32767, -32768, FMT_GRAY));
		push_cmd(cmd_byte(0, 0, 8'hC3));
		push_cmd(cmd_start(8, 8, 0, 0, 2'd2));
		push_cmd(cmd_byte(0, 0, 8'hFF));
		push_cmd(cmd_read(0, 12));
		push_cmd(cmd_start(20, 16, 192, 0, FMT_MONO));
		push_cmd(cmd_byte(0, 1, 8'h55));
		push_cmd(cmd_read(9, 0));
		push_cmd(cmd_start(16, 1, -100, -100, FMT_GRAY));
		push_cmd(cmd_byte(0, 3, 8'h5A));
		push_cmd(cmd_read(3, 13));

		run_phase(16, 16, 12, 0, 1, 0, 1'b0, 110);
		run_phase(64, 64, 40, 3, 3, 1, 1'b0, 130);
		run_phase(64, 64, 0, 0, 64, 1, 1'b1, 110);
		run_phase(1, 1, 0, 0, 1, 1, 1'b0, 80);
		run_phase(8, 64, -128, 127, 1, 1, 1'b0, 80);
		run_phase(64, 8, 127, -128, 127, 1, 1'b0, 80);
		run_phase(0, 0, 5, -5, 0, 1, 1'b0, 60);
		run_phase(0, 40, 10, 0, 2, 1, 1'b0, 40);
		run_phase(127, 127, 70, -10, 5, 1, 1'b0, 100);
		run_phase(100, 20, 15, 1, 3, 1, 1'b1, 80);
		for (p = 0; p < 5; p++)
			run_phase($urandom_range(1, 64), $urandom_range(1, 64),
				int'($urandom_range(0, 60)) - 10, int'($urandom_range(0, 20)) - 10,
				$urandom_range(1, 8), $urandom_range(0, 1), $urandom_range(0, 3) == 0, 100);
		drain();

		$display("Run covered %0d glyph commands (%0d starts, %0d pixel reads, %0d non-zero)",
			n_items, n_starts, n_reads, n_lit);
		$display("across %0d register settings, with random gaps, stalls and full-rate bursts",
			n_settings);
		if (fail_count == 0)
			$display("** glyph_alpha_blit_with_underline: PASSED **");
		else
			$display("** glyph_alpha_blit_with_underline: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/gab_pkg.sv
src/gab_if.sv
src/gab_lane.sv
src/gab_bank.sv
src/gab_merge.sv
src/glyph_alpha_blit_with_underline.sv
dv/tb.sv
